// ----- src/nlb_pkg.sv -----
// nlb_pkg: shared constants, register codes and stage types of the noise layer blend unit
// used by every module under src; depends on nothing
package nlb_pkg;

   localparam int DATA_W  = 16;
   localparam int FRAC_W  = 12;
   localparam int ALPHA_W = FRAC_W + 1;

   // stream and register port widths
   localparam int REQ_DATA_W = 2 * DATA_W;
   localparam int RSP_DATA_W = DATA_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = ALPHA_W;

   // weighted layer product, signed alpha (one extra bit) times layer
   localparam int WP_W   = ALPHA_W + 1 + DATA_W;
   // add and subtract sums
   localparam int SUM_W  = DATA_W + 2;
   // value carried through the divider chain: sums or the full product
   localparam int VAL_W  = 2 * DATA_W + 1;
   // divider: remainder, divisor, quotient and shifted divisor widths
   localparam int REM_W  = DATA_W + FRAC_W + 1;
   localparam int DEN_W  = DATA_W + 1;
   localparam int QUO_W  = DATA_W;
   localparam int CMP_W  = DEN_W + QUO_W;
   localparam int NUM_CELLS = QUO_W;
   // result before final saturation
   localparam int RES_W  = 2 * DATA_W - FRAC_W + 1;

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << FRAC_W;

   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA          = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_OVERFLOW_CLAMP = CSR_IDX_W'(2);

   // one slot of the divider chain
   typedef struct packed {
      logic             vld;
      logic [VAL_W-1:0] val;
      logic [REM_W-1:0] rem;
      logic [CMP_W-1:0] ds;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             dzero;
      logic             dovf;
   } nlb_cell_type;

   // finished result beat
   typedef struct packed {
      logic              vld;
      logic [DATA_W-1:0] value;
      logic              sat;
   } nlb_out_type;

endpackage

// ----- src/nlb_front.sv -----
// nlb_front: weighted layer multiply, rounding, and per-mode operand set-up (three stages)
// depends on nlb_pkg; feeds the first divider cell
module nlb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_vld,
   input  logic signed [nlb_pkg::DATA_W-1:0]  base_value,
   input  logic signed [nlb_pkg::DATA_W-1:0]  layer_value,
   input  logic [nlb_pkg::ALPHA_W-1:0]        alpha,
   input  logic [1:0]                         blend_mode,
   output nlb_pkg::nlb_cell_type              cell_next
);

   localparam int DW = nlb_pkg::DATA_W;
   localparam int FW = nlb_pkg::FRAC_W;
   localparam logic signed [nlb_pkg::WP_W-1:0] HALF_WP = nlb_pkg::WP_W'(1) << (FW - 1);

   // stage 1: alpha times layer
   logic                                 s1_vld_ff,  s1_vld_in;
   logic signed [DW-1:0]                 s1_base_ff, s1_base_in;
   logic signed [nlb_pkg::WP_W-1:0]      s1_prod_ff, s1_prod_in;
   logic [nlb_pkg::ALPHA_W-1:0]          a_lim;

   // stage 2: rounded weighted layer
   logic                                 s2_vld_ff,  s2_vld_in;
   logic signed [DW-1:0]                 s2_base_ff, s2_base_in;
   logic signed [nlb_pkg::DEN_W-1:0]     s2_d_ff,    s2_d_in;
   logic signed [nlb_pkg::WP_W-1:0]      wsum, wshift;

   // stage 3: operands for every mode
   nlb_pkg::nlb_cell_type                s3_ff, s3_in;
   logic signed [nlb_pkg::SUM_W-1:0]     b_ext, d_ext, add_s, sub_s;
   logic signed [nlb_pkg::VAL_W-1:0]     mul_p;
   logic [DW-1:0]                        mag_b;
   logic [nlb_pkg::DEN_W-1:0]            mag_d_full;
   logic [DW-1:0]                        mag_d;
   logic [nlb_pkg::REM_W-1:0]            num;
   logic [nlb_pkg::DEN_W-1:0]            den;

   always_comb begin
      a_lim      = (alpha > nlb_pkg::ALPHA_ONE) ? nlb_pkg::ALPHA_ONE : alpha;
      s1_vld_in  = in_vld;
      s1_base_in = base_value;
      s1_prod_in = $signed({1'b0, a_lim}) * layer_value;
   end

   always_comb begin
      wsum       = s1_prod_ff + HALF_WP;
      wshift     = wsum >>> FW;
      s2_vld_in  = s1_vld_ff;
      s2_base_in = s1_base_ff;
      s2_d_in    = wshift[nlb_pkg::DEN_W-1:0];
   end

   always_comb begin
      b_ext = {{(nlb_pkg::SUM_W-DW){s2_base_ff[DW-1]}}, s2_base_ff};
      d_ext = {{(nlb_pkg::SUM_W-nlb_pkg::DEN_W){s2_d_ff[nlb_pkg::DEN_W-1]}}, s2_d_ff};
      add_s = b_ext + d_ext;
      sub_s = b_ext - d_ext;
      mul_p = s2_base_ff * s2_d_ff;

      // magnitudes for the restoring divider, rounding folded in as (2n + m) / 2m
      mag_b      = s2_base_ff[DW-1] ? (~s2_base_ff + 1'b1) : s2_base_ff;
      mag_d_full = s2_d_ff[nlb_pkg::DEN_W-1] ? (~s2_d_ff + 1'b1) : s2_d_ff;
      mag_d      = mag_d_full[DW-1:0];
      num        = {mag_b, {FW{1'b0}}, 1'b0} + nlb_pkg::REM_W'(mag_d);
      den        = {mag_d, 1'b0};

      s3_in.vld = s2_vld_ff;
      case (blend_mode)
         nlb_pkg::MODE_ADD:
            s3_in.val = {{(nlb_pkg::VAL_W-nlb_pkg::SUM_W){add_s[nlb_pkg::SUM_W-1]}}, add_s};
         nlb_pkg::MODE_SUB:
            s3_in.val = {{(nlb_pkg::VAL_W-nlb_pkg::SUM_W){sub_s[nlb_pkg::SUM_W-1]}}, sub_s};
         default:
            s3_in.val = mul_p;
      endcase
      s3_in.rem   = num;
      s3_in.ds    = {den, {(nlb_pkg::QUO_W-1){1'b0}}, 1'b0} >> 1;
      s3_in.quo   = '0;
      s3_in.neg   = s2_base_ff[DW-1] ^ s2_d_ff[nlb_pkg::DEN_W-1];
      s3_in.dzero = (s2_d_ff == '0);
      // quotient would not fit the chain's bits
      s3_in.dovf  = (nlb_pkg::CMP_W'(num) >= {den, {nlb_pkg::QUO_W{1'b0}}});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_ff.vld <= 1'b0;
      end else if (adv) begin
         s1_vld_ff  <= s1_vld_in;
         s1_base_ff <= s1_base_in;
         s1_prod_ff <= s1_prod_in;
         s2_vld_ff  <= s2_vld_in;
         s2_base_ff <= s2_base_in;
         s2_d_ff    <= s2_d_in;
         s3_ff      <= s3_in;
      end
   end

   assign cell_next = s3_ff;

endmodule

// ----- src/nlb_div_cell.sv -----
// nlb_div_cell: one restoring-division cell, settles one quotient bit and passes the beat on
// depends on nlb_pkg
module nlb_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  nlb_pkg::nlb_cell_type cell_prev,
   output nlb_pkg::nlb_cell_type cell_next
);

   nlb_pkg::nlb_cell_type cell_ff, cell_in;
   logic                  ge;

   always_comb begin
      ge      = nlb_pkg::CMP_W'(cell_prev.rem) >= cell_prev.ds;
      cell_in = cell_prev;
      if (ge) begin
         cell_in.rem = cell_prev.rem - cell_prev.ds[nlb_pkg::REM_W-1:0];
      end
      cell_in.quo = {cell_prev.quo[nlb_pkg::QUO_W-2:0], ge};
      cell_in.ds  = cell_prev.ds >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_next = cell_ff;

endmodule

// ----- src/nlb_back.sv -----
// nlb_back: per-mode result select, product rounding, mode clamp and range saturation
// depends on nlb_pkg; takes the last divider cell's beat
module nlb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  nlb_pkg::nlb_cell_type cell_prev,
   input  logic [1:0]            blend_mode,
   input  logic                  overflow_clamp,
   output nlb_pkg::nlb_out_type  tail
);

   localparam int RW = nlb_pkg::RES_W;
   localparam int DW = nlb_pkg::DATA_W;
   localparam logic signed [RW-1:0] ONE_R     = RW'(1) << nlb_pkg::FRAC_W;
   localparam logic signed [RW-1:0] NEG_ONE_R = -(RW'(1) << nlb_pkg::FRAC_W);
   localparam logic signed [RW-1:0] MAX_R     = (RW'(1) << (DW - 1)) - RW'(1);
   localparam logic signed [RW-1:0] MIN_R     = -(RW'(1) << (DW - 1));
   localparam logic signed [nlb_pkg::VAL_W-1:0] HALF_V =
      nlb_pkg::VAL_W'(1) << (nlb_pkg::FRAC_W - 1);

   nlb_pkg::nlb_out_type            out_ff, out_in;
   logic signed [nlb_pkg::VAL_W-1:0] pround, pshift;
   logic signed [RW-1:0]             qext, r;

   always_comb begin
      pround = $signed(cell_prev.val) + HALF_V;
      pshift = pround >>> nlb_pkg::FRAC_W;
      qext   = $signed({{(RW-nlb_pkg::QUO_W){1'b0}}, cell_prev.quo});

      case (blend_mode)
         nlb_pkg::MODE_ADD: begin
            r = $signed(cell_prev.val[RW-1:0]);
            if (overflow_clamp && r > ONE_R) r = ONE_R;
         end
         nlb_pkg::MODE_SUB: begin
            r = $signed(cell_prev.val[RW-1:0]);
            if (overflow_clamp && r < NEG_ONE_R) r = NEG_ONE_R;
         end
         nlb_pkg::MODE_MUL: begin
            r = pshift[RW-1:0];
            if (overflow_clamp && r < NEG_ONE_R) r = NEG_ONE_R;
         end
         default: begin
            if (cell_prev.dzero) begin
               r = '0;
            end else if (cell_prev.dovf) begin
               // too large for the chain: any value past the sample range will do
               r = cell_prev.neg ? (MIN_R - RW'(1)) : (MAX_R + RW'(1));
            end else begin
               r = cell_prev.neg ? -qext : qext;
            end
            if (overflow_clamp) begin
               if (r > ONE_R) r = ONE_R;
               else if (r < 0) r = '0;
            end
         end
      endcase

      out_in.vld = cell_prev.vld;
      if (r > MAX_R) begin
         out_in.value = MAX_R[DW-1:0];
         out_in.sat   = 1'b1;
      end else if (r < MIN_R) begin
         out_in.value = MIN_R[DW-1:0];
         out_in.sat   = 1'b1;
      end else begin
         out_in.value = r[DW-1:0];
         out_in.sat   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign tail = out_ff;

endmodule

// ----- src/noise_layer_blend_unit.sv -----
// noise_layer_blend_unit: blends a base sample with an alpha-weighted layer sample, Q4.12
// each accepted req beat passes three set-up stages, a row of 16 division cells (one quotient
// bit each), one result stage and the output register on its way to its rsp beat.
// throughput one beat per cycle in every mode while rsp_tready stays high.
// a one-beat skid register behind the output keeps req_tready a registered signal.
// synchronous reset empties the pipeline and loads mode add, alpha 1.0, clamping on.
module noise_layer_blend_unit (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: base_value [15:0], layer_value [31:16]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nlb_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: blended_value [15:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nlb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: range_saturated [0]
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [nlb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nlb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DW = nlb_pkg::DATA_W;

   logic [1:0]                  blend_mode_ff;
   logic [nlb_pkg::ALPHA_W-1:0] alpha_ff;
   logic                        clamp_ff;

   logic                        adv;
   nlb_pkg::nlb_cell_type       chain [0:nlb_pkg::NUM_CELLS];
   nlb_pkg::nlb_out_type        tail;
   nlb_pkg::nlb_out_type        out_ff, out_in, skid_ff, skid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff <= nlb_pkg::MODE_ADD;
         alpha_ff      <= nlb_pkg::ALPHA_ONE;
         clamp_ff      <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            nlb_pkg::CSR_BLEND_MODE:     blend_mode_ff <= csr_wdata[1:0];
            nlb_pkg::CSR_ALPHA:          alpha_ff      <= csr_wdata;
            nlb_pkg::CSR_OVERFLOW_CLAMP: clamp_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves together; it only halts while the skid slot is taken
   assign adv        = ~skid_ff.vld;
   assign req_tready = adv;

   nlb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_vld      (req_tvalid),
      .base_value  ($signed(req_tdata[DW-1:0])),
      .layer_value ($signed(req_tdata[2*DW-1:DW])),
      .alpha       (alpha_ff),
      .blend_mode  (blend_mode_ff),
      .cell_next   (chain[0])
   );

   for (genvar i = 0; i < nlb_pkg::NUM_CELLS; i++) begin : g_cell
      nlb_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .cell_prev (chain[i]),
         .cell_next (chain[i+1])
      );
   end

   nlb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .adv            (adv),
      .cell_prev      (chain[nlb_pkg::NUM_CELLS]),
      .blend_mode     (blend_mode_ff),
      .overflow_clamp (clamp_ff),
      .tail           (tail)
   );

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (out_ff.vld && !rsp_tready) begin
         // output stalled: park the arriving beat
         if (adv && tail.vld) skid_in = tail;
      end else if (skid_ff.vld) begin
         out_in      = skid_ff;
         skid_in.vld = 1'b0;
      end else begin
         out_in = tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld  <= 1'b0;
         skid_ff.vld <= 1'b0;
      end else begin
         out_ff  <= out_in;
         skid_ff <= skid_in;
      end
   end

   assign rsp_tvalid = out_ff.vld;
   assign rsp_tdata  = out_ff.value;
   assign rsp_tuser  = out_ff.sat;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_ff.vld |-> out_ff.vld)
      else $error("skid slot holds a beat while the output register is empty");

   a_skid_only_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_ff.vld) |-> $past(out_ff.vld && !rsp_tready))
      else $error("skid slot filled without an output stall");

   a_sat_at_rail : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata == {1'b0, {(DW-1){1'b1}}} || rsp_tdata == {1'b1, {(DW-1){1'b0}}}))
      else $error("saturation flag raised on a value away from the range ends");

   a_div_clamp_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && blend_mode_ff == nlb_pkg::MODE_DIV && clamp_ff) |->
         (!rsp_tdata[DW-1] && rsp_tdata <= (DW'(1) << nlb_pkg::FRAC_W)))
      else $error("clamped divide result outside zero to one");

endmodule
